@@ src/smvn_pkg.sv @@
// Shared types, codes and constants of the vertex-normal engine.
`default_nettype none

package smvn_pkg;

   // Default sizes for the top-level parameters
   localparam int MAX_VERTICES_DEF = 1024;
   localparam int COORD_WIDTH_DEF  = 32;

   // Fixed field widths
   localparam int FIELD_W    = 32;
   localparam int IDX_W      = 10;
   localparam int CCOUNT_W   = 8;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int SUM_W      = 24;
   localparam int NRM_W      = 16;
   localparam int QUO_W      = 15;
   localparam int DIFF_W     = 33;
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 64;
   localparam int STEP_W     = 6;
   localparam int FACE_CORNERS = 3;

   // Beat layouts
   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 240;

   // Last step index of each multi-cycle phase
   localparam int MUL_LAST  = 6;
   localparam int SQ_LAST   = 3;
   localparam int SQRT_LAST = 32;
   localparam int DIV_LAST  = 15;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_VERTEX = 2'd1,
      OP_FACE   = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ABORT = 2'd1,
      ST_BAD   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SEL_A = 2'd0,
      SEL_B = 2'd1,
      SEL_C = 2'd2
   } corner_type;

   // Controller to datapath
   typedef struct packed {
      logic                start;
      logic                clear_mesh;
      logic                set_abort;
      logic                vtx_write;
      logic                vtx_rd;
      corner_type          sel;
      logic                diff;
      logic                fit;
      logic                mul_en;
      logic                sq_en;
      logic [STEP_W-1:0]   step;
      logic                load_face;
      logic                load_sum;
      logic                shift;
      logic                sqrt_init;
      logic                sqrt_step;
      logic                div_init;
      logic                div_step;
      logic                div_last;
      logic                sum_rd;
      logic                sum_wr;
      logic                rsp_load;
      status_type          status;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_type op;
      logic   aborted;
      logic   full;
      logic   tri_ok;
      logic   face_ok;
      logic   read_ok;
      logic   mag_big;
      logic   mag_zero;
   } flags_type;

endpackage

`default_nettype wire

@@ src/smooth_vertex_normals.sv @@
// Top level of the vertex-normal engine: controller plus datapath.
// Clear, vertex and rejected items finish at decode. A face fetches its corners, forms
// the edges and cross product, halves it while too big, squares it, takes the square
// root, divides and then updates the three corner sums; a read loads a sum and runs
// the same normalizer. A zero vector skips the root, divide and sum updates. One item
// at a time; the next beat is taken while a result waits. Reset (synchronous) empties the mesh.
`default_nettype none

module smooth_vertex_normals #(
   parameter int MAX_VERTICES = smvn_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = smvn_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // coord_x, coord_y, coord_z, corner_count, corner_a, corner_b, corner_c, read_index
   input  wire logic [smvn_pkg::REQ_DATA_W-1:0]  req_tdata,
   // operation
   input  wire logic [smvn_pkg::OP_W-1:0]        req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // normal_x, normal_y, normal_z, box_min_x/y/z, box_max_x/y/z
   output logic [smvn_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // status
   output logic [smvn_pkg::STATUS_W-1:0]         rsp_tuser
);

   smvn_pkg::cmd_type   cmd;
   smvn_pkg::flags_type flags;

   smvn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   smvn_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .flags     (flags),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

@@ src/smvn_datapath.sv @@
// Datapath: vertex and normal-sum memories, box, cross product, normalizer.
`default_nettype none

module smvn_datapath #(
   parameter int MAX_VERTICES = smvn_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = smvn_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [smvn_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [smvn_pkg::OP_W-1:0]         req_tuser,
   input  wire smvn_pkg::cmd_type                 cmd,
   output smvn_pkg::flags_type                    flags,
   output logic [smvn_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [smvn_pkg::STATUS_W-1:0]          rsp_tuser
);

   localparam int CW     = COORD_WIDTH;
   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int FW     = smvn_pkg::FIELD_W;
   localparam int SW     = smvn_pkg::SUM_W;
   localparam int NW     = smvn_pkg::NRM_W;
   localparam int QW     = smvn_pkg::QUO_W;
   localparam int DW     = smvn_pkg::DIFF_W;
   localparam int PW     = smvn_pkg::PROD_W;
   localparam int DIVW   = 46;
   localparam int VTX_W  = 3 * CW;
   localparam int SUMS_W = 3 * SW;

   // Latched request
   smvn_pkg::op_type                    op_ff;
   logic signed [CW-1:0]                coord_ff [3];
   logic [smvn_pkg::CCOUNT_W-1:0]       ccount_ff;
   logic [smvn_pkg::IDX_W-1:0]          ca_ff, cb_ff, cc_ff, ri_ff;

   // Mesh state
   logic [CNT_W-1:0]                    count_ff;
   logic                                aborted_ff;
   logic signed [CW-1:0]                box_lo_ff [3];
   logic signed [CW-1:0]                box_hi_ff [3];

   // Memories
   logic [VTX_W-1:0]                    vtx_mem [MAX_VERTICES];
   logic [SUMS_W-1:0]                   sum_mem [MAX_VERTICES];
   logic [VTX_W-1:0]                    vtx_q_ff;
   logic [SUMS_W-1:0]                   sum_q_ff;
   logic                                rd_pend_ff;
   smvn_pkg::corner_type                rd_sel_ff;

   // Face geometry
   logic signed [CW-1:0]                va_ff [3];
   logic signed [CW-1:0]                vb_ff [3];
   logic signed [CW-1:0]                vc_ff [3];
   logic signed [DW-1:0]                d1_ff [3];
   logic signed [DW-1:0]                d2_ff [3];
   logic signed [FW-1:0]                e1_ff [3];
   logic signed [FW-1:0]                e2_ff [3];
   logic signed [PW-1:0]                prod_ff;
   logic signed [PW-1:0]                n_ff [3];

   // Normalizer
   logic [PW-1:0]                       mag_ff [3];
   logic                                neg_ff [3];
   logic [PW-1:0]                       sq_ff;
   logic [PW-1:0]                       srem_ff, root_ff, bit_ff;
   logic [DIVW-1:0]                     dv_ff;
   logic [DIVW-1:0]                     drem_ff [3];
   logic [QW-1:0]                       qt_ff [3];
   logic signed [NW-1:0]                norm_ff [3];

   // Index checks
   function automatic logic idx_below(input logic [smvn_pkg::IDX_W-1:0] idx,
                                      input logic [CNT_W-1:0] cnt);
      idx_below = 32'(idx) < 32'(cnt);
   endfunction

   // Fit a 33-bit difference into 32 bits, halving magnitude when asked
   function automatic logic signed [FW-1:0] fit_val(input logic signed [DW-1:0] d,
                                                    input logic half);
      logic [DW-1:0] m;
      logic [FW-1:0] h;
      m = d[DW-1] ? DW'(-d) : DW'(d);
      h = m[DW-1:1];
      if (half)
         fit_val = d[DW-1] ? signed'(FW'(-h)) : signed'(h);
      else
         fit_val = d[FW-1:0];
   endfunction

   function automatic logic [DW-1:0] mag33(input logic signed [DW-1:0] d);
      mag33 = d[DW-1] ? DW'(-d) : DW'(d);
   endfunction

   logic big_d;
   always_comb begin
      big_d = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (mag33(d1_ff[i]) > DW'(33'h0_7FFF_FFFF)) big_d = 1'b1;
         if (mag33(d2_ff[i]) > DW'(33'h0_7FFF_FFFF)) big_d = 1'b1;
      end
   end

   // Addresses
   logic [smvn_pkg::IDX_W-1:0] corner_idx;
   always_comb begin
      unique case (cmd.sel)
         smvn_pkg::SEL_A: corner_idx = ca_ff;
         smvn_pkg::SEL_B: corner_idx = cb_ff;
         smvn_pkg::SEL_C: corner_idx = cc_ff;
         default:         corner_idx = ca_ff;
      endcase
   end

   logic [ADDR_W-1:0] sum_rd_addr;
   assign sum_rd_addr = (op_ff == smvn_pkg::OP_READ) ? ADDR_W'(ri_ff) : ADDR_W'(corner_idx);

   // Saturating add of the face normal onto a stored sum
   logic [SUMS_W-1:0] sum_upd;
   always_comb begin
      logic signed [SW:0] s;
      for (int i = 0; i < 3; i++) begin
         s = (SW+1)'(signed'(sum_q_ff[i*SW +: SW])) + (SW+1)'(norm_ff[i]);
         if (s > (SW+1)'(signed'(25'sd8388607)))
            sum_upd[i*SW +: SW] = SW'(24'h7F_FFFF);
         else if (s < (SW+1)'(-25'sd8388608))
            sum_upd[i*SW +: SW] = SW'(24'h80_0000);
         else
            sum_upd[i*SW +: SW] = s[SW-1:0];
      end
   end

   // Memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (cmd.vtx_write)
         vtx_mem[ADDR_W'(count_ff)] <= {coord_ff[2], coord_ff[1], coord_ff[0]};
      if (cmd.vtx_rd)
         vtx_q_ff <= vtx_mem[ADDR_W'(corner_idx)];
      if (cmd.vtx_write)
         sum_mem[ADDR_W'(count_ff)] <= '0;
      else if (cmd.sum_wr)
         sum_mem[ADDR_W'(corner_idx)] <= sum_upd;
      if (cmd.sum_rd)
         sum_q_ff <= sum_mem[sum_rd_addr];
   end

   // Request latch
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff       <= smvn_pkg::op_type'(req_tuser);
         coord_ff[0] <= CW'(req_tdata[31:0]);
         coord_ff[1] <= CW'(req_tdata[63:32]);
         coord_ff[2] <= CW'(req_tdata[95:64]);
         ccount_ff   <= req_tdata[103:96];
         ca_ff       <= req_tdata[113:104];
         cb_ff       <= req_tdata[123:114];
         cc_ff       <= req_tdata[133:124];
         ri_ff       <= req_tdata[143:134];
      end
   end

   // Mesh state: count, abort flag, bounding box
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_mesh) begin
         count_ff   <= '0;
         aborted_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            box_lo_ff[i] <= {1'b0, {(CW-1){1'b1}}};
            box_hi_ff[i] <= {1'b1, {(CW-1){1'b0}}};
         end
      end else begin
         if (cmd.set_abort) aborted_ff <= 1'b1;
         if (cmd.vtx_write) begin
            count_ff <= count_ff + CNT_W'(1);
            for (int i = 0; i < 3; i++) begin
               if (coord_ff[i] < box_lo_ff[i]) box_lo_ff[i] <= coord_ff[i];
               if (coord_ff[i] > box_hi_ff[i]) box_hi_ff[i] <= coord_ff[i];
            end
         end
      end
   end

   // Corner capture in the cycle after each vertex read
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.vtx_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.vtx_rd) rd_sel_ff <= cmd.sel;
      if (rd_pend_ff) begin
         for (int i = 0; i < 3; i++) begin
            unique case (rd_sel_ff)
               smvn_pkg::SEL_A: va_ff[i] <= vtx_q_ff[i*CW +: CW];
               smvn_pkg::SEL_B: vb_ff[i] <= vtx_q_ff[i*CW +: CW];
               smvn_pkg::SEL_C: vc_ff[i] <= vtx_q_ff[i*CW +: CW];
               default:         va_ff[i] <= vtx_q_ff[i*CW +: CW];
            endcase
         end
      end
   end

   // Edge vectors, then fit into 32 bits
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cmd.diff) begin
            d1_ff[i] <= DW'(vb_ff[i]) - DW'(va_ff[i]);
            d2_ff[i] <= DW'(vc_ff[i]) - DW'(va_ff[i]);
         end
         if (cmd.fit) begin
            e1_ff[i] <= fit_val(d1_ff[i], big_d);
            e2_ff[i] <= fit_val(d2_ff[i], big_d);
         end
      end
   end

   // Shared 32x32 multiplier: cross-product terms or squares
   logic signed [smvn_pkg::MUL_W-1:0] ma, mb;
   always_comb begin
      ma = '0;
      mb = '0;
      if (cmd.sq_en) begin
         unique case (cmd.step)
            6'd0:    ma = signed'(mag_ff[0][31:0]);
            6'd1:    ma = signed'(mag_ff[1][31:0]);
            6'd2:    ma = signed'(mag_ff[2][31:0]);
            default: ma = '0;
         endcase
         mb = ma;
      end else begin
         unique case (cmd.step)
            6'd0:    begin ma = e1_ff[1]; mb = e2_ff[2]; end
            6'd1:    begin ma = e1_ff[2]; mb = e2_ff[1]; end
            6'd2:    begin ma = e1_ff[2]; mb = e2_ff[0]; end
            6'd3:    begin ma = e1_ff[0]; mb = e2_ff[2]; end
            6'd4:    begin ma = e1_ff[0]; mb = e2_ff[1]; end
            6'd5:    begin ma = e1_ff[1]; mb = e2_ff[0]; end
            default: begin ma = '0; mb = '0; end
         endcase
      end
   end

   localparam int STEP_W_LOC = smvn_pkg::STEP_W;
   logic [STEP_W_LOC-1:0] prev_step;
   assign prev_step = cmd.step - STEP_W_LOC'(1);

   always_ff @(posedge clock) begin
      if (cmd.mul_en || cmd.sq_en)
         prod_ff <= ma * mb;
      // cross product: even term loads, odd term subtracts
      if (cmd.mul_en && cmd.step != '0) begin
         if (prev_step[0])
            n_ff[prev_step[2:1]] <= n_ff[prev_step[2:1]] - prod_ff;
         else
            n_ff[prev_step[2:1]] <= prod_ff;
      end
      if (cmd.sq_en && cmd.step != '0)
         sq_ff <= ((cmd.step == STEP_W_LOC'(1)) ? '0 : sq_ff) + unsigned'(prod_ff);
   end

   // Vector load and prescale
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cmd.load_face) begin
            neg_ff[i] <= n_ff[i][PW-1];
            mag_ff[i] <= n_ff[i][PW-1] ? PW'(-n_ff[i]) : PW'(n_ff[i]);
         end else if (cmd.load_sum) begin
            neg_ff[i] <= sum_q_ff[i*SW + SW - 1];
            mag_ff[i] <= sum_q_ff[i*SW + SW - 1]
                         ? PW'(-PW'(signed'(sum_q_ff[i*SW +: SW])))
                         : PW'(sum_q_ff[i*SW +: SW]);
         end else if (cmd.shift) begin
            mag_ff[i] <= mag_ff[i] >> 1;
         end
      end
   end

   // Bit-pair square root, one step a cycle
   logic [PW-1:0] rb;
   assign rb = root_ff + bit_ff;
   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         srem_ff <= sq_ff;
         root_ff <= '0;
         bit_ff  <= PW'(64'h4000_0000_0000_0000);
      end else if (cmd.sqrt_step) begin
         if (srem_ff >= rb) begin
            srem_ff <= srem_ff - rb;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // Three restoring dividers, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         for (int i = 0; i < 3; i++) norm_ff[i] <= '0;
      end
      if (cmd.div_init) begin
         dv_ff <= {root_ff[31:0], 14'b0};
         for (int i = 0; i < 3; i++) begin
            drem_ff[i] <= {2'b0, mag_ff[i][29:0], 14'b0} + DIVW'(root_ff[31:1]);
            qt_ff[i]   <= '0;
         end
      end else if (cmd.div_step) begin
         dv_ff <= dv_ff >> 1;
         for (int i = 0; i < 3; i++) begin
            logic          ge;
            logic [QW-1:0] qn;
            ge = drem_ff[i] >= dv_ff;
            qn = {qt_ff[i][QW-2:0], ge};
            if (ge) drem_ff[i] <= drem_ff[i] - dv_ff;
            qt_ff[i] <= qn;
            if (cmd.div_last)
               norm_ff[i] <= neg_ff[i] ? signed'(NW'(-NW'(qn))) : signed'(NW'(qn));
         end
      end
   end

   // Result beat
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         for (int i = 0; i < 3; i++) begin
            rsp_tdata[i*NW +: NW] <= (op_ff == smvn_pkg::OP_READ &&
                                      cmd.status == smvn_pkg::ST_OK) ? norm_ff[i] : '0;
            rsp_tdata[48 + i*FW +: FW]  <= FW'(box_lo_ff[i]);
            rsp_tdata[144 + i*FW +: FW] <= FW'(box_hi_ff[i]);
         end
         rsp_tuser <= cmd.status;
      end
   end

   // Status back to the controller
   always_comb begin
      flags.op       = op_ff;
      flags.aborted  = aborted_ff;
      flags.full     = count_ff == CNT_W'(MAX_VERTICES);
      flags.tri_ok   = ccount_ff == smvn_pkg::CCOUNT_W'(smvn_pkg::FACE_CORNERS);
      flags.face_ok  = idx_below(ca_ff, count_ff) && idx_below(cb_ff, count_ff) &&
                       idx_below(cc_ff, count_ff);
      flags.read_ok  = idx_below(ri_ff, count_ff);
      flags.mag_big  = (|mag_ff[0][PW-1:30]) || (|mag_ff[1][PW-1:30]) ||
                       (|mag_ff[2][PW-1:30]);
      flags.mag_zero = (mag_ff[0] == '0) && (mag_ff[1] == '0) && (mag_ff[2] == '0);
   end

endmodule

`default_nettype wire

@@ src/smvn_ctrl.sv @@
// Controller: sequences each item through the datapath and owns the handshakes.
`default_nettype none

module smvn_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire smvn_pkg::flags_type  flags,
   output smvn_pkg::cmd_type         cmd
);

   localparam int SW = smvn_pkg::STEP_W;

   typedef enum logic [17:0] {
      S_IDLE    = 18'h00001,
      S_DECODE  = 18'h00002,
      S_FETCH_A = 18'h00004,
      S_FETCH_B = 18'h00008,
      S_FETCH_C = 18'h00010,
      S_VWAIT   = 18'h00020,
      S_DIFF    = 18'h00040,
      S_FIT     = 18'h00080,
      S_MUL     = 18'h00100,
      S_NLOAD   = 18'h00200,
      S_RSUM    = 18'h00400,
      S_RLOAD   = 18'h00800,
      S_NSHIFT  = 18'h01000,
      S_SQUARE  = 18'h02000,
      S_SQRT    = 18'h04000,
      S_DIV     = 18'h08000,
      S_SUM_RD  = 18'h10000,
      S_SUM_WR  = 18'h20000
   } state_type;

   state_type               state_ff, state_in;
   logic [SW-1:0]           step_ff, step_in;
   smvn_pkg::status_type    status_ff, status_in;
   smvn_pkg::corner_type    corner_ff, corner_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    done_ff, done_in;

   assign req_tready = (state_ff == S_IDLE) && !done_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = '0;
      status_in    = status_ff;
      corner_in    = corner_ff;
      done_in      = done_ff;
      cmd          = '0;
      cmd.sel      = corner_ff;
      cmd.step     = step_ff;
      cmd.status   = status_ff;

      // finished beat leaves as soon as the output slot is free
      if (done_ff && (!rsp_valid_ff || rsp_tready)) begin
         cmd.rsp_load = 1'b1;
         done_in      = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && !done_ff) begin
               cmd.start = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = smvn_pkg::ST_OK;
            corner_in = smvn_pkg::SEL_A;
            state_in  = S_IDLE;
            done_in   = 1'b1;
            if (flags.op == smvn_pkg::OP_CLEAR) begin
               cmd.clear_mesh = 1'b1;
            end else if (flags.aborted) begin
               status_in = smvn_pkg::ST_ABORT;
            end else begin
               unique case (flags.op)
                  smvn_pkg::OP_VERTEX: begin
                     if (flags.full) status_in = smvn_pkg::ST_BAD;
                     else            cmd.vtx_write = 1'b1;
                  end
                  smvn_pkg::OP_FACE: begin
                     if (!flags.tri_ok) begin
                        cmd.set_abort = 1'b1;
                        status_in     = smvn_pkg::ST_ABORT;
                     end else if (!flags.face_ok) begin
                        status_in = smvn_pkg::ST_BAD;
                     end else begin
                        state_in = S_FETCH_A;
                        done_in  = 1'b0;
                     end
                  end
                  smvn_pkg::OP_READ: begin
                     if (!flags.read_ok) begin
                        status_in = smvn_pkg::ST_BAD;
                     end else begin
                        state_in = S_RSUM;
                        done_in  = 1'b0;
                     end
                  end
                  default: status_in = smvn_pkg::ST_OK;
               endcase
            end
         end
         S_FETCH_A: begin
            cmd.vtx_rd = 1'b1;
            cmd.sel    = smvn_pkg::SEL_A;
            state_in   = S_FETCH_B;
         end
         S_FETCH_B: begin
            cmd.vtx_rd = 1'b1;
            cmd.sel    = smvn_pkg::SEL_B;
            state_in   = S_FETCH_C;
         end
         S_FETCH_C: begin
            cmd.vtx_rd = 1'b1;
            cmd.sel    = smvn_pkg::SEL_C;
            state_in   = S_VWAIT;
         end
         S_VWAIT:  state_in = S_DIFF;
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_FIT;
         end
         S_FIT: begin
            cmd.fit  = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            if (step_ff == SW'(smvn_pkg::MUL_LAST)) state_in = S_NLOAD;
            else                                    step_in  = step_ff + SW'(1);
         end
         S_NLOAD: begin
            cmd.load_face = 1'b1;
            state_in      = S_NSHIFT;
         end
         S_RSUM: begin
            cmd.sum_rd = 1'b1;
            state_in   = S_RLOAD;
         end
         S_RLOAD: begin
            cmd.load_sum = 1'b1;
            state_in     = S_NSHIFT;
         end
         S_NSHIFT: begin
            if (flags.mag_big) begin
               cmd.shift = 1'b1;
            end else if (flags.mag_zero) begin
               state_in = S_IDLE;
               done_in  = 1'b1;
            end else begin
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            cmd.sq_en = 1'b1;
            if (step_ff == SW'(smvn_pkg::SQ_LAST)) state_in = S_SQRT;
            else                                   step_in  = step_ff + SW'(1);
         end
         S_SQRT: begin
            cmd.sqrt_init = (step_ff == '0);
            cmd.sqrt_step = (step_ff != '0);
            if (step_ff == SW'(smvn_pkg::SQRT_LAST)) state_in = S_DIV;
            else                                     step_in  = step_ff + SW'(1);
         end
         S_DIV: begin
            cmd.div_init = (step_ff == '0);
            cmd.div_step = (step_ff != '0);
            cmd.div_last = (step_ff == SW'(smvn_pkg::DIV_LAST));
            if (step_ff == SW'(smvn_pkg::DIV_LAST)) begin
               if (flags.op == smvn_pkg::OP_FACE) begin
                  state_in = S_SUM_RD;
               end else begin
                  state_in = S_IDLE;
                  done_in  = 1'b1;
               end
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         S_SUM_RD: begin
            cmd.sum_rd = 1'b1;
            state_in   = S_SUM_WR;
         end
         S_SUM_WR: begin
            cmd.sum_wr = 1'b1;
            unique case (corner_ff)
               smvn_pkg::SEL_A: begin
                  corner_in = smvn_pkg::SEL_B;
                  state_in  = S_SUM_RD;
               end
               smvn_pkg::SEL_B: begin
                  corner_in = smvn_pkg::SEL_C;
                  state_in  = S_SUM_RD;
               end
               default: begin
                  state_in = S_IDLE;
                  done_in  = 1'b1;
               end
            endcase
         end
         default: state_in = S_IDLE;
      endcase

      if (cmd.rsp_load)         rsp_valid_in = 1'b1;
      else if (rsp_tready)      rsp_valid_in = 1'b0;
      else                      rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         status_ff    <= smvn_pkg::ST_OK;
         corner_ff    <= smvn_pkg::SEL_A;
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         status_ff    <= status_in;
         corner_ff    <= corner_in;
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
      end
   end

endmodule

`default_nettype wire
